// File: hw/rtl/bjeru_pkg.sv
`default_nettype none

package bjeru_pkg;

    // Default parameter values
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ENTRY_BITS_DEF   = 16;

    // Datapath widths: Q30 vectors with CORDIC growth, Q20 angles
    localparam int VW    = 38;
    localparam int ZW    = 24;
    localparam int IW    = 5;
    localparam int QB    = 34;
    localparam int DCW   = 6;
    localparam int Q30_W = 32;
    localparam int NUM_W = 62;

    localparam logic signed [ZW-1:0] PI_Q20      = 24'sd3294199;
    localparam logic signed [ZW-1:0] HALF_PI_Q20 = 24'sd1647099;
    localparam logic signed [ZW-1:0] PI_Q13      = 24'sd25736;
    localparam logic signed [VW-1:0] GAIN_Q30    = 38'sd652032874;

    // Elementary CORDIC angles atan(2^-i), Q20
    function automatic logic signed [ZW-1:0] atan_q20(input logic [IW-1:0] idx);
        logic signed [ZW-1:0] r;
        unique case (idx)
            5'd0:    r = 24'sd823550;
            5'd1:    r = 24'sd486170;
            5'd2:    r = 24'sd256879;
            5'd3:    r = 24'sd130396;
            5'd4:    r = 24'sd65451;
            5'd5:    r = 24'sd32757;
            5'd6:    r = 24'sd16383;
            5'd7:    r = 24'sd8192;
            5'd8:    r = 24'sd4096;
            5'd9:    r = 24'sd2048;
            5'd10:   r = 24'sd1024;
            5'd11:   r = 24'sd512;
            5'd12:   r = 24'sd256;
            5'd13:   r = 24'sd128;
            5'd14:   r = 24'sd64;
            5'd15:   r = 24'sd32;
            5'd16:   r = 24'sd16;
            5'd17:   r = 24'sd8;
            5'd18:   r = 24'sd4;
            5'd19:   r = 24'sd2;
            5'd20:   r = 24'sd1;
            default: r = 24'sd0;
        endcase
        return r;
    endfunction

    // Round a Q20 angle to Q3.13 and clamp to plus or minus pi
    function automatic logic signed [15:0] round_q13(input logic signed [ZW-1:0] z);
        logic signed [ZW-1:0] t;
        t = (z + 24'sd64) >>> 7;
        if (t > PI_Q13) begin
            t = PI_Q13;
        end else if (t < -PI_Q13) begin
            t = -PI_Q13;
        end
        return t[15:0];
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ball_joint_euler_rotation_unit.sv
// Flow: each CORDIC pass is load, CORDIC_STEPS iterations, then finish. Mode 0 runs one pass
//   per updated angle, two for y with a radix-2 divide of QB quotient bits between them
//   (skipped when the divisor is zero). Mode 1 runs one pass; axis three, or mode 0 with
//   every angle held, goes straight to the result beat.
// Throughput: one item at a time; the next beat can be taken in the cycle after the result beat.
// Reset: synchronous active-low aresetn clears held angles, mask_reg and control.
`default_nettype none

module ball_joint_euler_rotation_unit #(
    parameter int CORDIC_STEPS = bjeru_pkg::CORDIC_STEPS_DEF,
    parameter int ENTRY_BITS   = bjeru_pkg::ENTRY_BITS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [2:0]                   cfg_data,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic                         s_mode,
    input  wire logic [1:0]                   s_axis,
    input  wire logic [1:0]                   s_order,
    input  wire logic                         s_fixed_also,
    input  wire logic signed [ENTRY_BITS-1:0] s_m00,
    input  wire logic signed [ENTRY_BITS-1:0] s_m01,
    input  wire logic signed [ENTRY_BITS-1:0] s_m02,
    input  wire logic signed [ENTRY_BITS-1:0] s_m12,
    input  wire logic signed [ENTRY_BITS-1:0] s_m22,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic signed [ENTRY_BITS-1:0]      m_e00,
    output logic signed [ENTRY_BITS-1:0]      m_e01,
    output logic signed [ENTRY_BITS-1:0]      m_e02,
    output logic signed [ENTRY_BITS-1:0]      m_e10,
    output logic signed [ENTRY_BITS-1:0]      m_e11,
    output logic signed [ENTRY_BITS-1:0]      m_e12,
    output logic signed [ENTRY_BITS-1:0]      m_e20,
    output logic signed [ENTRY_BITS-1:0]      m_e21,
    output logic signed [ENTRY_BITS-1:0]      m_e22,
    output logic signed [15:0]                m_angle_z,
    output logic signed [15:0]                m_angle_y,
    output logic signed [15:0]                m_angle_x
);

    localparam int VW  = bjeru_pkg::VW;
    localparam int ZW  = bjeru_pkg::ZW;
    localparam int IW  = bjeru_pkg::IW;
    localparam int QB  = bjeru_pkg::QB;
    localparam int DCW = bjeru_pkg::DCW;
    localparam int QW  = bjeru_pkg::Q30_W;
    localparam int NW  = bjeru_pkg::NUM_W;
    localparam int SH  = 32 - ENTRY_BITS;
    localparam int EB  = ENTRY_BITS;

    localparam logic signed [VW-1:0] ENT_RND =
        VW'(SH == 0 ? 64'sd0 : (64'sd1 <<< (SH - 1)));
    localparam logic signed [VW-1:0] ONE_V = VW'(64'sd1 <<< (EB - 2));
    localparam logic signed [EB-1:0] ONE_E = EB'(64'sd1 <<< (EB - 2));
    localparam logic [IW-1:0]  LAST_IT = IW'(CORDIC_STEPS - 1);
    localparam logic [DCW-1:0] LAST_DC = DCW'(QB - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_RUN  = 3'd2;
    localparam logic [2:0] S_FIN  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    localparam logic [2:0] P_ZATAN = 3'd0;
    localparam logic [2:0] P_YSC   = 3'd1;
    localparam logic [2:0] P_YATAN = 3'd2;
    localparam logic [2:0] P_XATAN = 3'd3;
    localparam logic [2:0] P_EMIT  = 3'd4;

    // Registers
    logic [2:0]              state_reg, state_next;
    logic [2:0]              phase_reg, phase_next;
    logic [2:0]              mask_reg, mask_next;
    logic signed [15:0]      held_reg [3];
    logic signed [15:0]      held_next [3];
    logic [1:0]              axis_reg, axis_next;
    logic [1:0]              order_reg, order_next;
    logic                    upd_y_reg, upd_y_next;
    logic                    upd_x_reg, upd_x_next;
    logic signed [QW-1:0]    m00_reg, m00_next;
    logic signed [QW-1:0]    m01_reg, m01_next;
    logic signed [QW-1:0]    m02_reg, m02_next;
    logic signed [QW-1:0]    m12_reg, m12_next;
    logic signed [QW-1:0]    m22_reg, m22_next;
    logic signed [VW-1:0]    x_reg, x_next;
    logic signed [VW-1:0]    y_reg, y_next;
    logic signed [ZW-1:0]    z_reg, z_next;
    logic [IW-1:0]           it_reg, it_next;
    logic                    rot_reg, rot_next;
    logic                    neg_reg, neg_next;
    logic                    zero_reg, zero_next;
    logic [VW-1:0]           rem_reg, rem_next;
    logic [VW-1:0]           den_reg, den_next;
    logic [QB-1:0]           nlo_reg, nlo_next;
    logic [QB-1:0]           quo_reg, quo_next;
    logic                    dneg_reg, dneg_next;
    logic [DCW-1:0]          dc_reg, dc_next;
    logic signed [EB-1:0]    e_reg [9];
    logic signed [EB-1:0]    e_next [9];

    // Combinational helpers
    logic                    take;
    logic                    upd_z_in;
    logic                    upd_y_in;
    logic                    upd_x_in;
    logic signed [EB-1:0]    u_in;
    logic signed [EB-1:0]    u_cur;
    logic signed [VW-1:0]    vy;
    logic signed [VW-1:0]    vx;
    logic signed [VW-1:0]    qs;
    logic signed [15:0]      ang;
    logic signed [ZW-1:0]    za;
    logic signed [VW-1:0]    dx;
    logic signed [VW-1:0]    dy;
    logic signed [ZW-1:0]    at;
    logic                    down;
    logic signed [VW-1:0]    cs_c;
    logic signed [VW-1:0]    cs_s;
    logic [VW-1:0]           abs_c;
    logic [VW-1:0]           abs_s;
    logic                    use_c;
    logic signed [QW-1:0]    num_m;
    logic [QW-1:0]           num_abs;
    logic [NW-1:0]           num_full;
    logic [VW-1:0]           den_sel;
    logic signed [15:0]      ang_res;
    logic [VW-1:0]           r2;
    logic                    qbit;
    logic signed [EB-1:0]    cr;
    logic signed [EB-1:0]    sr;
    logic signed [EB-1:0]    ce;
    logic signed [EB-1:0]    se;

    // Round a Q30 value to an entry and clamp to plus or minus one
    function automatic logic signed [EB-1:0] to_entry(input logic signed [VW-1:0] v);
        logic signed [VW-1:0] t;
        t = (v + ENT_RND) >>> SH;
        if (t > ONE_V) begin
            t = ONE_V;
        end else if (t < -ONE_V) begin
            t = -ONE_V;
        end
        return t[EB-1:0];
    endfunction

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = (state_reg == S_OUT);
    assign take      = s_valid && s_ready;

    assign upd_z_in = s_fixed_also || !mask_reg[0];
    assign upd_y_in = s_fixed_also || !mask_reg[1];
    assign upd_x_in = s_fixed_also || !mask_reg[2];
    assign u_in     = (s_order == 2'd0) ? ONE_E : '0;
    assign u_cur    = (order_reg == 2'd0) ? ONE_E : '0;

    // Select the CORDIC job operands by phase
    assign qs = dneg_reg ? -$signed({{(VW-QB){1'b0}}, quo_reg})
                         : $signed({{(VW-QB){1'b0}}, quo_reg});
    always_comb begin
        unique case (phase_reg)
            P_ZATAN: begin
                vy = VW'(m01_reg);
                vx = VW'(m00_reg);
            end
            P_YATAN: begin
                vy = -VW'(m02_reg);
                vx = qs;
            end
            P_XATAN: begin
                vy = VW'(m12_reg);
                vx = VW'(m22_reg);
            end
            default: begin
                vy = '0;
                vx = '0;
            end
        endcase
    end
    assign ang = (phase_reg == P_YSC) ? held_reg[0] : held_reg[axis_reg];
    assign za  = ZW'(ang) <<< 7;

    // Shared CORDIC iteration
    assign dx   = y_reg >>> it_reg;
    assign dy   = x_reg >>> it_reg;
    assign at   = bjeru_pkg::atan_q20(it_reg);
    assign down = rot_reg ? !z_reg[ZW-1] : y_reg[VW-1];

    // Post-pass values
    assign cs_c    = neg_reg ? -x_reg : x_reg;
    assign cs_s    = neg_reg ? -y_reg : y_reg;
    assign abs_c   = cs_c[VW-1] ? VW'(-cs_c) : VW'(cs_c);
    assign abs_s   = cs_s[VW-1] ? VW'(-cs_s) : VW'(cs_s);
    assign use_c   = abs_c > abs_s;
    assign num_m   = use_c ? m00_reg : m01_reg;
    assign num_abs = num_m[QW-1] ? QW'(-num_m) : QW'(num_m);
    assign num_full = {num_abs, 30'b0};
    assign den_sel = use_c ? abs_c : abs_s;
    assign ang_res = zero_reg ? 16'sd0 : bjeru_pkg::round_q13(z_reg);

    // Divider step
    assign r2   = {rem_reg[VW-2:0], nlo_reg[QB-1]};
    assign qbit = (r2 >= den_reg);

    // Rotation entries with the phase shift of the derivative order
    assign cr = to_entry(cs_c);
    assign sr = to_entry(cs_s);
    always_comb begin
        unique case (order_reg)
            2'd1: begin
                ce = -sr;
                se = cr;
            end
            2'd2: begin
                ce = -cr;
                se = -sr;
            end
            2'd3: begin
                ce = sr;
                se = -cr;
            end
            default: begin
                ce = cr;
                se = sr;
            end
        endcase
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        mask_next  = mask_reg;
        for (int i = 0; i < 3; i++) begin
            held_next[i] = held_reg[i];
        end
        for (int i = 0; i < 9; i++) begin
            e_next[i] = e_reg[i];
        end
        axis_next  = axis_reg;
        order_next = order_reg;
        upd_y_next = upd_y_reg;
        upd_x_next = upd_x_reg;
        m00_next   = m00_reg;
        m01_next   = m01_reg;
        m02_next   = m02_reg;
        m12_next   = m12_reg;
        m22_next   = m22_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        it_next    = it_reg;
        rot_next   = rot_reg;
        neg_next   = neg_reg;
        zero_next  = zero_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        nlo_next   = nlo_reg;
        quo_next   = quo_reg;
        dneg_next  = dneg_reg;
        dc_next    = dc_reg;

        if (cfg_valid && cfg_ready) begin
            mask_next = cfg_data;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (take) begin
                    axis_next  = s_axis;
                    order_next = s_order;
                    upd_y_next = upd_y_in;
                    upd_x_next = upd_x_in;
                    m00_next   = QW'(s_m00) <<< SH;
                    m01_next   = QW'(s_m01) <<< SH;
                    m02_next   = QW'(s_m02) <<< SH;
                    m12_next   = QW'(s_m12) <<< SH;
                    m22_next   = QW'(s_m22) <<< SH;
                    for (int i = 0; i < 9; i++) begin
                        e_next[i] = '0;
                    end
                    if (!s_mode) begin
                        state_next = S_LOAD;
                        priority if (upd_z_in) begin
                            phase_next = P_ZATAN;
                        end else if (upd_y_in) begin
                            phase_next = P_YSC;
                        end else if (upd_x_in) begin
                            phase_next = P_XATAN;
                        end else begin
                            state_next = S_OUT;
                        end
                    end else if (s_axis == 2'd3) begin
                        e_next[0]  = u_in;
                        e_next[4]  = u_in;
                        e_next[8]  = u_in;
                        state_next = S_OUT;
                    end else begin
                        phase_next = P_EMIT;
                        state_next = S_LOAD;
                    end
                end
            end
            S_LOAD: begin
                it_next    = '0;
                state_next = S_RUN;
                if (phase_reg == P_YSC || phase_reg == P_EMIT) begin
                    rot_next  = 1'b1;
                    zero_next = 1'b0;
                    x_next    = bjeru_pkg::GAIN_Q30;
                    y_next    = '0;
                    priority if (za > bjeru_pkg::HALF_PI_Q20) begin
                        z_next   = za - bjeru_pkg::PI_Q20;
                        neg_next = 1'b1;
                    end else if (za < -bjeru_pkg::HALF_PI_Q20) begin
                        z_next   = za + bjeru_pkg::PI_Q20;
                        neg_next = 1'b1;
                    end else begin
                        z_next   = za;
                        neg_next = 1'b0;
                    end
                end else begin
                    rot_next  = 1'b0;
                    neg_next  = 1'b0;
                    zero_next = (vx == '0) && (vy == '0);
                    if (vx[VW-1]) begin
                        x_next = -vx;
                        y_next = -vy;
                        z_next = vy[VW-1] ? -bjeru_pkg::PI_Q20 : bjeru_pkg::PI_Q20;
                    end else begin
                        x_next = vx;
                        y_next = vy;
                        z_next = '0;
                    end
                end
            end
            S_RUN: begin
                if (down) begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - at;
                end else begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + at;
                end
                it_next = it_reg + 1'b1;
                if (it_reg == LAST_IT) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                unique case (phase_reg)
                    P_ZATAN: begin
                        held_next[0] = ang_res;
                        state_next   = S_LOAD;
                        priority if (upd_y_reg) begin
                            phase_next = P_YSC;
                        end else if (upd_x_reg) begin
                            phase_next = P_XATAN;
                        end else begin
                            state_next = S_OUT;
                        end
                    end
                    P_YSC: begin
                        rem_next  = VW'(num_full[NW-1:QB]);
                        nlo_next  = num_full[QB-1:0];
                        den_next  = den_sel;
                        dneg_next = num_m[QW-1] ^ (use_c ? cs_c[VW-1] : cs_s[VW-1]);
                        dc_next   = '0;
                        quo_next  = '0;
                        if (den_sel == '0) begin
                            dneg_next  = 1'b0;
                            phase_next = P_YATAN;
                            state_next = S_LOAD;
                        end else begin
                            state_next = S_DIV;
                        end
                    end
                    P_YATAN: begin
                        held_next[1] = ang_res;
                        if (upd_x_reg) begin
                            phase_next = P_XATAN;
                            state_next = S_LOAD;
                        end else begin
                            state_next = S_OUT;
                        end
                    end
                    P_XATAN: begin
                        held_next[2] = ang_res;
                        state_next   = S_OUT;
                    end
                    default: begin
                        unique case (axis_reg)
                            2'd0: begin
                                e_next[0] = ce;
                                e_next[1] = se;
                                e_next[3] = -se;
                                e_next[4] = ce;
                                e_next[8] = u_cur;
                            end
                            2'd1: begin
                                e_next[0] = ce;
                                e_next[2] = -se;
                                e_next[4] = u_cur;
                                e_next[6] = se;
                                e_next[8] = ce;
                            end
                            default: begin
                                e_next[0] = u_cur;
                                e_next[4] = ce;
                                e_next[5] = se;
                                e_next[7] = -se;
                                e_next[8] = ce;
                            end
                        endcase
                        state_next = S_OUT;
                    end
                endcase
            end
            S_DIV: begin
                rem_next = qbit ? (r2 - den_reg) : r2;
                quo_next = {quo_reg[QB-2:0], qbit};
                nlo_next = {nlo_reg[QB-2:0], 1'b0};
                dc_next  = dc_reg + 1'b1;
                if (dc_reg == LAST_DC) begin
                    phase_next = P_YATAN;
                    state_next = S_LOAD;
                end
            end
            S_OUT: begin
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state with reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            phase_reg <= P_ZATAN;
            mask_reg  <= '0;
            for (int i = 0; i < 3; i++) begin
                held_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            mask_reg  <= mask_next;
            for (int i = 0; i < 3; i++) begin
                held_reg[i] <= held_next[i];
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        for (int i = 0; i < 9; i++) begin
            e_reg[i] <= e_next[i];
        end
        axis_reg  <= axis_next;
        order_reg <= order_next;
        upd_y_reg <= upd_y_next;
        upd_x_reg <= upd_x_next;
        m00_reg   <= m00_next;
        m01_reg   <= m01_next;
        m02_reg   <= m02_next;
        m12_reg   <= m12_next;
        m22_reg   <= m22_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        z_reg     <= z_next;
        it_reg    <= it_next;
        rot_reg   <= rot_next;
        neg_reg   <= neg_next;
        zero_reg  <= zero_next;
        rem_reg   <= rem_next;
        den_reg   <= den_next;
        nlo_reg   <= nlo_next;
        quo_reg   <= quo_next;
        dneg_reg  <= dneg_next;
        dc_reg    <= dc_next;
    end

    // Drive result ports
    assign m_e00     = e_reg[0];
    assign m_e01     = e_reg[1];
    assign m_e02     = e_reg[2];
    assign m_e10     = e_reg[3];
    assign m_e11     = e_reg[4];
    assign m_e12     = e_reg[5];
    assign m_e20     = e_reg[6];
    assign m_e21     = e_reg[7];
    assign m_e22     = e_reg[8];
    assign m_angle_z = held_reg[0];
    assign m_angle_y = held_reg[1];
    assign m_angle_x = held_reg[2];

    // Checks
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input and result beat offered together");

    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("ready right after accepting a beat");

    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> (den_reg != '0))
        else $error("divider running with zero divisor");

    a_run_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RUN) |-> (it_reg <= LAST_IT))
        else $error("CORDIC iteration count overran");

endmodule

`default_nettype wire

// File: tb/bjeru_checker.sv
`timescale 1ns / 100ps
`default_nettype none

module bjeru_checker (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_valid,
    input  wire logic               cfg_ready,
    input  wire logic [2:0]         cfg_data,
    input  wire logic               s_valid,
    input  wire logic               s_ready,
    input  wire logic               s_mode,
    input  wire logic [1:0]         s_axis,
    input  wire logic [1:0]         s_order,
    input  wire logic               s_fixed_also,
    input  wire logic signed [15:0] s_m00,
    input  wire logic signed [15:0] s_m01,
    input  wire logic signed [15:0] s_m02,
    input  wire logic signed [15:0] s_m12,
    input  wire logic signed [15:0] s_m22,
    input  wire logic               m_valid,
    input  wire logic               m_ready,
    input  wire logic signed [15:0] m_e [9],
    input  wire logic signed [15:0] m_angle_z,
    input  wire logic signed [15:0] m_angle_y,
    input  wire logic signed [15:0] m_angle_x,
    output int                      fail_count,
    output int                      pending_count
);

    localparam longint PI20  = 3294199;
    localparam longint HPI20 = 1647099;
    localparam longint PI13  = 25736;
    localparam longint GAIN  = 652032874;
    localparam int     STEPS = 16;
    localparam longint ONE14 = 16384;

    typedef struct {
        logic signed [15:0] e [9];
        logic signed [15:0] ang [3];
    } pose_result_t;

    pose_result_t expected_poses [$];
    longint joint_angle [3];
    logic [2:0] hold_mask;

    function automatic longint atan_step(input int i);
        longint tab [24] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
                             4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1,
                             0, 0, 0};
        return tab[i];
    endfunction

    function automatic longint lim(input longint v, input longint l);
        return v > l ? l : (v < -l ? -l : v);
    endfunction

    task automatic rotate_sincos(input longint a13, output longint c, output longint s);
        longint z, x, y, dx, dy;
        bit neg;
        z = a13 * 128; x = GAIN; y = 0; neg = 0;
        if (z > HPI20) begin
            z -= PI20; neg = 1;
        end else if (z < -HPI20) begin
            z += PI20; neg = 1;
        end
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_step(i);
            end else begin
                x += dx; y -= dy; z += atan_step(i);
            end
        end
        c = neg ? -x : x;
        s = neg ? -y : y;
    endtask

    function automatic longint vector_angle(input longint y0, input longint x0);
        longint z, x, y, dx, dy;
        x = x0; y = y0; z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? PI20 : -PI20;
            x = -x; y = -y;
        end
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += atan_step(i);
            end else begin
                x -= dx; y += dy; z -= atan_step(i);
            end
        end
        return lim((z + 64) >>> 7, PI13);
    endfunction

    function automatic longint q30_to_entry(input longint v);
        return lim((v + 32768) >>> 16, ONE14);
    endfunction

    // Update held angles or build the axis matrix for one input beat
    task automatic predict_pose();
        pose_result_t r;
        longint a00, a01, a02, a12, a22, c, s, cr, sr, q, u;
        longint e [9];
        bit every;
        a00 = longint'(s_m00) * 65536; a01 = longint'(s_m01) * 65536;
        a02 = longint'(s_m02) * 65536; a12 = longint'(s_m12) * 65536;
        a22 = longint'(s_m22) * 65536;
        every = s_fixed_also;
        foreach (e[j]) e[j] = 0;
        if (!s_mode) begin
            if (every || !hold_mask[0]) joint_angle[0] = vector_angle(a01, a00);
            if (every || !hold_mask[1]) begin
                rotate_sincos(joint_angle[0], c, s);
                if ((c < 0 ? -c : c) > (s < 0 ? -s : s))
                    q = c != 0 ? (a00 * (64'sd1 << 30)) / c : 0;
                else
                    q = s != 0 ? (a01 * (64'sd1 << 30)) / s : 0;
                joint_angle[1] = vector_angle(-a02, q);
            end
            if (every || !hold_mask[2]) joint_angle[2] = vector_angle(a12, a22);
        end else begin
            u = s_order == 0 ? ONE14 : 0;
            if (s_axis == 3) begin
                e[0] = u; e[4] = u; e[8] = u;
            end else begin
                rotate_sincos(joint_angle[s_axis], cr, sr);
                cr = q30_to_entry(cr);
                sr = q30_to_entry(sr);
                case (s_order)
                    2'd1: begin c = -sr; s = cr; end
                    2'd2: begin c = -cr; s = -sr; end
                    2'd3: begin c = sr; s = -cr; end
                    default: begin c = cr; s = sr; end
                endcase
                if (s_axis == 0) begin
                    e[0] = c; e[1] = s; e[3] = -s; e[4] = c; e[8] = u;
                end else if (s_axis == 1) begin
                    e[0] = c; e[2] = -s; e[4] = u; e[6] = s; e[8] = c;
                end else begin
                    e[0] = u; e[4] = c; e[5] = s; e[7] = -s; e[8] = c;
                end
            end
        end
        foreach (e[j]) r.e[j] = e[j][15:0];
        foreach (joint_angle[j]) r.ang[j] = joint_angle[j][15:0];
        expected_poses.push_back(r);
    endtask

    assign pending_count = expected_poses.size();

    always @(posedge aclk) begin
        pose_result_t x;
        logic signed [15:0] got [3];
        if (!aresetn) begin
            foreach (joint_angle[j]) joint_angle[j] = 0;
            hold_mask = '0;
            expected_poses.delete();
        end else begin
            // Compare the output beat before predicting from this edge's input
            if (m_valid && m_ready) begin
                if (expected_poses.size() == 0) begin
                    $display("%0t: result beat with nothing expected", $realtime);
                    fail_count++;
                end else begin
                    x = expected_poses.pop_front();
                    got[0] = m_angle_z; got[1] = m_angle_y; got[2] = m_angle_x;
                    for (int j = 0; j < 9; j++)
                        if (m_e[j] !== x.e[j]) begin
                            $display("%0t: e%0d%0d expected %0d actual %0d", $realtime,
                                     j / 3, j % 3, x.e[j], m_e[j]);
                            fail_count++;
                        end
                    for (int j = 0; j < 3; j++)
                        if (got[j] !== x.ang[j]) begin
                            $display("%0t: angle[%0d] expected %0d actual %0d", $realtime,
                                     j, x.ang[j], got[j]);
                            fail_count++;
                        end
                end
            end
            if (cfg_valid && cfg_ready) hold_mask = cfg_data;
            if (s_valid && s_ready) predict_pose();
        end
    end

    initial fail_count = 0;

endmodule

`default_nettype wire

// File: tb/tb_ball_joint_euler_rotation_unit.sv
`timescale 1ns / 100ps
`default_nettype none

module tb_ball_joint_euler_rotation_unit;

    localparam int CYCLE_LIMIT = 600000;

    logic aclk, aresetn;
    logic cfg_valid, cfg_ready;
    logic [2:0] cfg_data;
    logic s_valid, s_ready, s_mode, s_fixed_also;
    logic [1:0] s_axis, s_order;
    logic signed [15:0] s_m00, s_m01, s_m02, s_m12, s_m22;
    logic m_valid, m_ready;
    logic signed [15:0] m_e [9];
    logic signed [15:0] m_angle_z, m_angle_y, m_angle_x;
    int fail_count, pending_count, cycle_count;
    bit calm;

    ball_joint_euler_rotation_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode), .s_axis(s_axis),
        .s_order(s_order), .s_fixed_also(s_fixed_also),
        .s_m00(s_m00), .s_m01(s_m01), .s_m02(s_m02), .s_m12(s_m12), .s_m22(s_m22),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_e00(m_e[0]), .m_e01(m_e[1]), .m_e02(m_e[2]),
        .m_e10(m_e[3]), .m_e11(m_e[4]), .m_e12(m_e[5]),
        .m_e20(m_e[6]), .m_e21(m_e[7]), .m_e22(m_e[8]),
        .m_angle_z(m_angle_z), .m_angle_y(m_angle_y), .m_angle_x(m_angle_x)
    );

    bjeru_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode), .s_axis(s_axis),
        .s_order(s_order), .s_fixed_also(s_fixed_also),
        .s_m00(s_m00), .s_m01(s_m01), .s_m02(s_m02), .s_m12(s_m12), .s_m22(s_m22),
        .m_valid(m_valid), .m_ready(m_ready), .m_e(m_e),
        .m_angle_z(m_angle_z), .m_angle_y(m_angle_y), .m_angle_x(m_angle_x),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // End the run on a stuck handshake
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Stall the result side in random bursts
    initial begin
        int n;
        m_ready = 0;
        forever begin
            @(negedge aclk);
            if (calm || $urandom_range(0, 3) != 0) begin
                m_ready <= 1;
            end else begin
                m_ready <= 0;
                n = $urandom_range(1, 17);
                repeat (n - 1) @(negedge aclk);
            end
        end
    end

    function automatic logic signed [15:0] rand_entry();
        case ($urandom_range(0, 5))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'sd0;
            3: return $signed(16'($urandom));
            default: return $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
        endcase
    endfunction

    // Hold valid across back-to-back beats; drop it only before an idle burst
    task automatic send_item(input logic mode, input logic [1:0] ax, input logic [1:0] ord,
                             input logic every, input logic signed [15:0] a, b, c, d, e);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 17)) @(negedge aclk);
        end
        s_valid <= 1; s_mode <= mode; s_axis <= ax; s_order <= ord;
        s_fixed_also <= every;
        s_m00 <= a; s_m01 <= b; s_m02 <= c; s_m12 <= d; s_m22 <= e;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic send_random();
        send_item($urandom_range(0, 1), $urandom_range(0, 3), $urandom_range(0, 3),
                  $urandom_range(0, 1), rand_entry(), rand_entry(), rand_entry(),
                  rand_entry(), rand_entry());
    endtask

    // Drain outstanding results, then let the block settle before a register write
    task automatic write_mask(input logic [2:0] v);
        s_valid <= 0;
        while (pending_count != 0) @(negedge aclk);
        repeat (120) @(negedge aclk);
        cfg_valid <= 1; cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 0;
    endtask

    initial begin
        logic [2:0] masks [5] = '{3'd7, 3'd0, 3'd5, 3'd2, 3'd0};
        calm = 0; cycle_count = 0;
        aresetn = 0; cfg_valid = 0; cfg_data = 0; s_valid = 0;
        s_mode = 0; s_axis = 0; s_order = 0; s_fixed_also = 0;
        s_m00 = 0; s_m01 = 0; s_m02 = 0; s_m12 = 0; s_m22 = 0;
        repeat (3) @(negedge aclk);
        aresetn = 1;

        // Directed: zero matrix, extremes, every axis and order, axis three
        send_item(0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_item(0, 0, 0, 0, 16384, 0, 0, 0, 16384);
        send_item(0, 0, 0, 0, -16384, 16384, -16384, 16384, -16384);
        send_item(0, 0, 0, 1, -16384, -1, 16384, -1, -16384);
        send_item(0, 0, 0, 0, 0, 16384, 0, 16384, 0);
        send_item(0, 0, 0, 0, -32768, 32767, -32768, 32767, -32768);
        for (int ax = 0; ax < 4; ax++)
            for (int o = 0; o < 4; o++)
                send_item(1, 2'(ax), 2'(o), 0, 0, 0, 0, 0, 0);
        write_mask(3'd7);
        send_item(0, 0, 0, 0, 1000, 2000, 3000, 4000, 5000);
        send_item(0, 0, 0, 1, 12000, -9000, 4000, 7000, -3000);

        // Random, in phases across mask settings
        for (int p = 0; p < 5; p++) begin
            write_mask(masks[p]);
            if (p == 4) calm = 1;
            repeat (190) send_random();
        end

        s_valid <= 0;
        while (pending_count != 0) @(negedge aclk);
        repeat (120) @(negedge aclk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire
